>>> src/spd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg
// Widths, register map, stage records and helpers shared by the
// simultaneous press detector.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int MASK_W     = 8;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 16;
    localparam int IDX_W      = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [THR_W-1:0] THRESH_RESET = 16'd50;

    // register index taken from paddr above the byte offset
    localparam logic [APB_ADDR_W-3:0] REG_THRESHOLD = 1'b0;

    typedef struct packed {
        logic              pressed;
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
    } spd_lane_t;

    typedef struct packed {
        logic              any;
        logic              multi;
        logic [TIME_W-1:0] earliest;
        logic [TIME_W-1:0] latest;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  second;
    } spd_merge_t;

    function automatic logic [IDX_W-1:0] lowest_index(input logic [MASK_W-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = MASK_W - 1; k >= 0; k--)
        begin
            if (m[k])
            begin
                idx = IDX_W'(k);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

>>> src/spd_tick_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_tick_if
// Tick channel: debounced button mask and current millisecond time.
// ----------------------------------------------------------------------------
interface spd_tick_if;
    logic                       valid;
    logic                       ready;
    logic [spd_pkg::MASK_W-1:0] pressed_mask;
    logic [spd_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output pressed_mask, output now_ms, input ready);
    modport sink   (input valid, input pressed_mask, input now_ms, output ready);
endinterface
`default_nettype wire

>>> src/spd_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_result_if
// Result channel: detection flag and the two lowest pressed buttons.
// ----------------------------------------------------------------------------
interface spd_result_if;
    logic                      valid;
    logic                      ready;
    logic                      report;
    logic [spd_pkg::IDX_W-1:0] first_button;
    logic [spd_pkg::IDX_W-1:0] second_button;

    modport source (output valid, output report, output first_button,
                    output second_button, input ready);
    modport sink   (input valid, input report, input first_button,
                    input second_button, output ready);
endinterface
`default_nettype wire

>>> src/spd_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_lane
// One button: edge detect, press time capture and the lane's min/max
// candidates for the merge stage.
// ----------------------------------------------------------------------------
module spd_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       pressed,
    input  logic [spd_pkg::TIME_W-1:0] now_ms,
    output spd_pkg::spd_lane_t         lane
);
    import spd_pkg::*;

    logic              prev_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    spd_lane_t         lane_reg;
    spd_lane_t         lane_next;

    always_comb
    begin
        start_next        = (pressed && !prev_reg) ? now_ms : start_reg;
        lane_next.pressed = pressed;
        lane_next.lo      = pressed ? start_next : now_ms;
        lane_next.hi      = pressed ? start_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            start_reg <= '0;
        end
        else if (load)
        begin
            prev_reg  <= pressed;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule
`default_nettype wire

>>> src/spd_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_merge
// Combine the lanes: earliest and latest press time over a min/max tree,
// pressed count class and the two lowest pressed indices.
// ----------------------------------------------------------------------------
module spd_merge #(
    parameter int LANES = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid_in,
    output logic                       ready_in,
    input  spd_pkg::spd_lane_t         lanes [LANES],
    input  logic [spd_pkg::TIME_W-1:0] now_ms,
    output logic                       valid_out,
    input  logic                       ready_out,
    output spd_pkg::spd_merge_t        info
);
    import spd_pkg::*;

    localparam int L1 = MASK_W / 2;
    localparam int L2 = MASK_W / 4;

    logic [MASK_W-1:0] leaf_p;
    logic [TIME_W-1:0] leaf_lo [MASK_W];
    logic [TIME_W-1:0] leaf_hi [MASK_W];
    logic [TIME_W-1:0] l1_lo [L1];
    logic [TIME_W-1:0] l1_hi [L1];
    logic [TIME_W-1:0] l2_lo [L2];
    logic [TIME_W-1:0] l2_hi [L2];
    logic [TIME_W-1:0] l3_lo;
    logic              valid_reg;
    spd_merge_t        info_reg;
    spd_merge_t        info_next;

    for (genvar j = 0; j < MASK_W; j++)
    begin : g_leaf
        if (j < LANES)
        begin : g_real
            assign leaf_p[j]  = lanes[j].pressed;
            assign leaf_lo[j] = lanes[j].lo;
            assign leaf_hi[j] = lanes[j].hi;
        end
        else
        begin : g_pad
            assign leaf_p[j]  = 1'b0;
            assign leaf_lo[j] = now_ms;
            assign leaf_hi[j] = '0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < L1; k++)
        begin
            l1_lo[k] = (leaf_lo[2*k+1] < leaf_lo[2*k]) ? leaf_lo[2*k+1] : leaf_lo[2*k];
            l1_hi[k] = (leaf_hi[2*k+1] > leaf_hi[2*k]) ? leaf_hi[2*k+1] : leaf_hi[2*k];
        end
        for (int k = 0; k < L2; k++)
        begin
            l2_lo[k] = (l1_lo[2*k+1] < l1_lo[2*k]) ? l1_lo[2*k+1] : l1_lo[2*k];
            l2_hi[k] = (l1_hi[2*k+1] > l1_hi[2*k]) ? l1_hi[2*k+1] : l1_hi[2*k];
        end
        l3_lo              = (l2_lo[1] < l2_lo[0]) ? l2_lo[1] : l2_lo[0];
        info_next.earliest = (now_ms < l3_lo) ? now_ms : l3_lo;
        info_next.latest   = (l2_hi[1] > l2_hi[0]) ? l2_hi[1] : l2_hi[0];
        info_next.any      = |leaf_p;
        info_next.multi    = |(leaf_p & (leaf_p - MASK_W'(1)));
        info_next.first    = lowest_index(leaf_p);
        info_next.second   = lowest_index(leaf_p & (leaf_p - MASK_W'(1)));
    end

    assign ready_in = !valid_reg || ready_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (valid_in && ready_in)
        begin
            valid_reg <= 1'b1;
        end
        else if (ready_out)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_in)
        begin
            info_reg <= info_next;
        end
    end

    assign valid_out = valid_reg;
    assign info      = info_reg;

endmodule
`default_nettype wire

>>> src/spd_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spd_decide
// Spread check against the threshold, reported flag and the result register.
// ----------------------------------------------------------------------------
module spd_decide (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    output logic                      ready_in,
    input  spd_pkg::spd_merge_t       info,
    input  logic [spd_pkg::THR_W-1:0] threshold_ms,
    spd_result_if.source              result
);
    import spd_pkg::*;

    logic              flag_reg;
    logic              flag_next;
    logic              valid_reg;
    logic              report_reg;
    logic [IDX_W-1:0]  first_reg;
    logic [IDX_W-1:0]  second_reg;
    logic [TIME_W-1:0] spread;
    logic              hit;
    logic              take;

    assign ready_in = !valid_reg || result.ready;
    assign take     = valid_in && ready_in;
    assign spread   = info.latest - info.earliest;
    assign hit      = info.multi && !flag_reg && (spread <= TIME_W'(threshold_ms));

    always_comb
    begin
        flag_next = flag_reg;
        if (!info.any)
        begin
            flag_next = 1'b0;
        end
        else if (hit)
        begin
            flag_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            flag_reg  <= flag_next;
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            report_reg <= hit;
            first_reg  <= hit ? info.first : '0;
            second_reg <= hit ? info.second : '0;
        end
    end

    assign result.valid         = valid_reg;
    assign result.report        = report_reg;
    assign result.first_button  = first_reg;
    assign result.second_button = second_reg;

`ifndef SYNTHESIS
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && report_reg) |-> (first_reg < second_reg))
        else $error("reported buttons out of order");

    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !report_reg) |-> (first_reg == '0 && second_reg == '0))
        else $error("button indices set without report");

    a_flag_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flag_reg) |-> (valid_reg && report_reg))
        else $error("flag set without a report");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (take && $past(flag_reg) == 1'b1 && flag_reg) |-> !hit)
        else $error("second report while flag set");
`endif

endmodule
`default_nettype wire

>>> src/simultaneous_press_detector.sv
`default_nettype none
// Path: a tick passes through the lane, merge and decide registers before its result is valid.
// Throughput: one tick per cycle while result.ready is high; every stage advances independently under backpressure.
// The lane registers and the merge register let ticks enter while a result waits.
// Reset: rst_n clears button history, press times, reported flag and all valid bits;
// threshold_ms returns to 50.
// ----------------------------------------------------------------------------
// simultaneous_press_detector
// Tracks press times of debounced buttons and reports the two lowest
// buttons when several are pressed within threshold_ms of each other.
// ----------------------------------------------------------------------------
module simultaneous_press_detector #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    spd_tick_if.sink                       tick,
    spd_result_if.source                   result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import spd_pkg::*;

    localparam int LANES = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;

    logic [THR_W-1:0]  threshold_reg;
    logic              thr_sel;
    logic              s1_valid_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              tick_take;
    logic              merge_ready;
    logic              merge_valid;
    logic              decide_ready;
    spd_lane_t         lanes [LANES];
    spd_merge_t        merge_info;

    assign pready  = 1'b1;
    assign thr_sel = (paddr[APB_ADDR_W-1:2] == REG_THRESHOLD);
    assign prdata  = thr_sel ? APB_DATA_W'(threshold_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else if (psel && penable && pwrite && pready && thr_sel)
        begin
            threshold_reg <= pwdata[THR_W-1:0];
        end
    end

    assign tick.ready = !s1_valid_reg || merge_ready;
    assign tick_take  = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (merge_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            s1_now_reg <= tick.now_ms;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        spd_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (tick_take),
            .pressed (tick.pressed_mask[i]),
            .now_ms  (tick.now_ms),
            .lane    (lanes[i])
        );
    end

    spd_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid_reg),
        .ready_in  (merge_ready),
        .lanes     (lanes),
        .now_ms    (s1_now_reg),
        .valid_out (merge_valid),
        .ready_out (decide_ready),
        .info      (merge_info)
    );

    spd_decide u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_in     (merge_valid),
        .ready_in     (decide_ready),
        .info         (merge_info),
        .threshold_ms (threshold_reg),
        .result       (result)
    );

endmodule
`default_nettype wire
